// ===== design/pfcs_pkg.sv =====
// Shared types and constants for the prefix fused cosine scorer.
// No dependencies.
package pfcs_pkg;
  localparam int ELEM_W = 16;
  localparam int ACC_W  = 48;
  localparam int IDX_W  = 13;
  localparam int COS_W  = 16;
  localparam logic [IDX_W-1:0] IDX_MAX = 13'd8191;
  localparam logic [IDX_W-1:0] COARSE_RESET = 13'd64;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Sums of one finished vector handed from accumulator to scorer
  typedef struct packed {
    logic signed [ACC_W-1:0] dot_full;
    logic signed [ACC_W-1:0] nq_full;
    logic signed [ACC_W-1:0] nc_full;
    logic signed [ACC_W-1:0] dot_pre;
    logic signed [ACC_W-1:0] nq_pre;
    logic signed [ACC_W-1:0] nc_pre;
    logic                    use_pre;
  } sums_t;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_ROOT, S_MUL, S_DIV, S_RND, S_NEXT, S_FUSE, S_DIV5, S_OUT
  } score_state_t;

  // Saturating 48-bit add of a sign-extended 32-bit product
  function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] a, input logic signed [ACC_W-1:0] p);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {p[ACC_W-1], p};
    if (s[ACC_W] != s[ACC_W-1]) sat_add = s[ACC_W] ? ACC_MIN : ACC_MAX;
    else sat_add = s[ACC_W-1:0];
  endfunction
endpackage

// ===== design/pfcs_front.sv =====
// Front end: element pair accumulator with prefix sums.
// Depends on pfcs_pkg.
module pfcs_front import pfcs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [IDX_W-1:0]        coarse_len,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [ELEM_W-1:0] in_query_element,
  input  logic signed [ELEM_W-1:0] in_candidate_element,
  input  logic                    in_last_element,
  output logic                    q_valid,
  input  logic                    q_full,
  output sums_t                   q_data
);
  logic signed [ACC_W-1:0] dfa_r, nqf_r, ncf_r, dpa_r, nqp_r, ncp_r;
  logic [IDX_W-1:0] idx_r;
  logic signed [2*ELEM_W-1:0] ab, aa, bb;
  logic signed [ACC_W-1:0] dfa_nxt, nqf_nxt, ncf_nxt, dpa_nxt, nqp_nxt, ncp_nxt;
  logic [IDX_W-1:0] idx_nxt;
  logic acc, in_pre;

  // stall any word while the sums queue is full
  assign in_stall = q_full;
  assign acc = in_valid && !in_stall;
  assign ab = in_query_element * in_candidate_element;
  assign aa = in_query_element * in_query_element;
  assign bb = in_candidate_element * in_candidate_element;
  assign in_pre = idx_r < coarse_len;

  always_comb begin
    dfa_nxt = sat_add(dfa_r, ACC_W'(ab));
    nqf_nxt = sat_add(nqf_r, ACC_W'(aa));
    ncf_nxt = sat_add(ncf_r, ACC_W'(bb));
    dpa_nxt = in_pre ? sat_add(dpa_r, ACC_W'(ab)) : dpa_r;
    nqp_nxt = in_pre ? sat_add(nqp_r, ACC_W'(aa)) : nqp_r;
    ncp_nxt = in_pre ? sat_add(ncp_r, ACC_W'(bb)) : ncp_r;
    idx_nxt = (idx_r < IDX_MAX) ? idx_r + 1'b1 : idx_r;
  end

  assign q_valid = acc && in_last_element;
  assign q_data = '{dot_full: dfa_nxt, nq_full: nqf_nxt, nc_full: ncf_nxt,
                    dot_pre: dpa_nxt, nq_pre: nqp_nxt, nc_pre: ncp_nxt,
                    use_pre: (coarse_len != '0) && (idx_nxt >= coarse_len)};

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_last_element)) begin
      dfa_r <= '0; nqf_r <= '0; ncf_r <= '0;
      dpa_r <= '0; nqp_r <= '0; ncp_r <= '0;
      idx_r <= '0;
    end else if (acc) begin
      dfa_r <= dfa_nxt; nqf_r <= nqf_nxt; ncf_r <= ncf_nxt;
      dpa_r <= dpa_nxt; nqp_r <= nqp_nxt; ncp_r <= ncp_nxt;
      idx_r <= idx_nxt;
    end
  end

  property p_idx_clear;
    @(posedge clk) disable iff (!rst_n) (acc && in_last_element) |=> idx_r == '0;
  endproperty
  a_idx_clear: assert property (p_idx_clear) else $error("index not cleared");
  a_norm_pos: assert property (@(posedge clk) disable iff (!rst_n)
    nqf_r >= 0 && ncp_r >= 0) else $error("norm sum negative");
  a_pre_le: assert property (@(posedge clk) disable iff (!rst_n)
    nqp_r <= nqf_r) else $error("prefix norm exceeds full");
endmodule

// ===== design/pfcs_queue.sv =====
// Two-entry queue of vector sums between accumulator and scorer.
// Depends on pfcs_pkg.
module pfcs_queue import pfcs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  sums_t wr_data,
  output logic  full,
  output logic  rd_valid,
  input  logic  rd_en,
  output sums_t rd_data
);
  sums_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full)) else $error("queue overflow");
  a_no_unf: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && !rd_valid)) else $error("queue underflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count out of range");
endmodule

// ===== design/pfcs_score.sv =====
// Back end: sequential cosine scorer (normalize, root, divide, fuse).
// Depends on pfcs_pkg.
module pfcs_score import pfcs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  input  sums_t q_data,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_stall,
  output logic signed [COS_W-1:0] out_full_cosine,
  output logic signed [COS_W-1:0] out_coarse_cosine,
  output logic signed [COS_W-1:0] out_fused_score
);
  score_state_t st_r, st_nxt;
  sums_t s_r;
  logic pass_r;          // 0: full, 1: prefix
  logic [63:0] vq_r, vc_r;          // normalized norms
  logic [5:0] kq_r, kc_r;
  logic [63:0] xq_r, xc_r, rq_r, rc_r, bit_r; // root state
  logic [63:0] den_r, rem_r;
  logic [16:0] quo_r;
  logic [47:0] mag_r;
  logic neg_r, zero_r;
  logic [6:0] shift_r;
  logic [7:0] p_r;
  logic signed [COS_W-1:0] full_r, coarse_r, fused_r;
  logic signed [18:0] sum_r;
  logic [17:0] fm_r;
  logic vout_r;

  logic [64:0] rnext;
  logic bin;
  logic [16:0] qn;
  logic [63:0] tq, tc;
  logic [16:0] qr;
  logic signed [COS_W-1:0] cres;
  logic [6:0] pm;
  logic [33:0] fprod;
  logic [15:0] fq;

  // one bit of the long division per cycle
  assign pm = 7'(p_r - {1'b0, shift_r});
  assign bin = (p_r >= {1'b0, shift_r}) && (pm < 7'd48) ? mag_r[pm[5:0]] : 1'b0;
  always_comb begin
    rnext = {rem_r, bin};
    qn = {quo_r[15:0], 1'b0};
    if (rnext >= {1'b0, den_r}) begin
      rnext = rnext - {1'b0, den_r};
      qn = qn + 1'b1;
    end
    if (qn > 17'd65535) qn = 17'd65535;
  end
  assign tq = rq_r + bit_r;
  assign tc = rc_r + bit_r;
  assign qr = (rem_r >= den_r - rem_r) ? quo_r + 1'b1 : quo_r;
  always_comb begin
    if (zero_r) cres = '0;
    else if (qr > 17'd16384) cres = neg_r ? -16'sd16384 : 16'sd16384;
    else cres = neg_r ? -COS_W'(qr) : COS_W'(qr);
  end

  // divide by five: reciprocal multiply, exact for magnitudes below 2^18
  assign fprod = 34'(fm_r) * 34'd52429;
  assign fq = fprod[33:18];

  assign out_valid = vout_r;
  assign out_full_cosine = full_r;
  assign out_coarse_cosine = coarse_r;
  assign out_fused_score = fused_r;
  assign q_pop = (st_r == S_IDLE) && q_valid && !vout_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (q_pop) st_nxt = S_NORM;
      S_NORM: if (zero_r || (kq_r == 6'd31 || (vq_r << 2) >= 64'h4000_0000_0000_0000)
                 && (kc_r == 6'd31 || (vc_r << 2) >= 64'h4000_0000_0000_0000))
                st_nxt = zero_r ? S_RND : S_ROOT;
      S_ROOT: if (bit_r == '0) st_nxt = S_MUL;
      S_MUL:  st_nxt = S_DIV;
      S_DIV:  if (p_r == '0) st_nxt = S_RND;
      S_RND:  st_nxt = S_NEXT;
      S_NEXT: st_nxt = (!pass_r && s_r.use_pre) ? S_NORM : S_FUSE;
      S_FUSE: st_nxt = S_DIV5;
      S_DIV5: st_nxt = S_OUT;
      S_OUT:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      vout_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (vout_r && !out_stall) vout_r <= 1'b0;
      else if (st_r == S_OUT) vout_r <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: if (q_pop) begin
        s_r <= q_data; pass_r <= 1'b0;
        vq_r <= 64'(q_data.nq_full); vc_r <= 64'(q_data.nc_full);
        kq_r <= '0; kc_r <= '0;
        zero_r <= (q_data.nq_full <= 0) || (q_data.nc_full <= 0);
        neg_r <= q_data.dot_full < 0;
        mag_r <= q_data.dot_full < 0 ? 48'(-q_data.dot_full) : 48'(q_data.dot_full);
      end
      S_NORM: begin
        if (kq_r != 6'd31 && (vq_r << 2) < 64'h4000_0000_0000_0000) begin
          vq_r <= vq_r << 2; kq_r <= kq_r + 1'b1;
        end
        if (kc_r != 6'd31 && (vc_r << 2) < 64'h4000_0000_0000_0000) begin
          vc_r <= vc_r << 2; kc_r <= kc_r + 1'b1;
        end
        xq_r <= vq_r; xc_r <= vc_r; rq_r <= '0; rc_r <= '0;
        bit_r <= 64'h4000_0000_0000_0000;
        quo_r <= '0;
      end
      S_ROOT: if (bit_r != '0) begin
        // both roots step together; start bit is common, leading zeros harmless
        if (xq_r >= tq) begin xq_r <= xq_r - tq; rq_r <= (rq_r >> 1) + bit_r; end
        else rq_r <= rq_r >> 1;
        if (xc_r >= tc) begin xc_r <= xc_r - tc; rc_r <= (rc_r >> 1) + bit_r; end
        else rc_r <= rc_r >> 1;
        bit_r <= bit_r >> 2;
      end
      S_MUL: begin
        den_r <= {rq_r[31:0]} * {rc_r[31:0]};
        rem_r <= '0; quo_r <= '0;
        shift_r <= 7'd14 + {1'b0, kq_r} + {1'b0, kc_r};
        p_r <= 8'd61 + {1'b0, kq_r} + {1'b0, kc_r};
      end
      S_DIV: begin
        if (den_r == '0) zero_r <= 1'b1;
        rem_r <= rnext[63:0]; quo_r <= qn;
        if (p_r != '0) p_r <= p_r - 1'b1;
      end
      S_RND: begin
        if (!pass_r) begin full_r <= cres; coarse_r <= cres; end
        else coarse_r <= cres;
      end
      S_NEXT: begin
        pass_r <= 1'b1;
        vq_r <= 64'(s_r.nq_pre); vc_r <= 64'(s_r.nc_pre);
        kq_r <= '0; kc_r <= '0;
        zero_r <= (s_r.nq_pre <= 0) || (s_r.nc_pre <= 0);
        neg_r <= s_r.dot_pre < 0;
        mag_r <= s_r.dot_pre < 0 ? 48'(-s_r.dot_pre) : 48'(s_r.dot_pre);
      end
      S_FUSE: begin
        sum_r <= 19'(3 * 19'(full_r)) + 19'(2 * 19'(coarse_r));
        fm_r <= (full_r*3 + coarse_r*2 >= 0) ?
                18'(19'(3 * 19'(full_r)) + 19'(2 * 19'(coarse_r)) + 19'sd2) :
                18'(-(19'(3 * 19'(full_r)) + 19'(2 * 19'(coarse_r))) + 19'sd2);
      end
      S_DIV5: begin
        // rounded magnitude over five, sign restored
        fused_r <= sum_r < 0 ? -COS_W'(fq) : COS_W'(fq);
      end
      default: ;
    endcase
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !vout_r) else $error("pop while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vout_r && out_stall) |=> vout_r && $stable(fused_r)) else $error("result dropped");
  a_cos_rng: assert property (@(posedge clk) disable iff (!rst_n)
    vout_r |-> (full_r <= 16'sd16384 && full_r >= -16'sd16384))
    else $error("cosine out of range");
endmodule

// ===== design/prefix_fused_cosine_scorer_top.sv =====
// Channel  Dir  Ports
// in       in   in_valid/in_stall, in_query_element, in_candidate_element, in_last_element
// out      out  out_valid/out_stall, out_full_cosine, out_coarse_cosine, out_fused_score
// cfg      in   cfg_valid/cfg_ready, cfg_coarse_length
// One element word per cycle while in_stall is low; a last word queues its sums for the scorer.
// Scoring runs normalize, the root and the bit-serial divide (root and divide skipped
// for zero norms) once for the full sums and, when the prefix applies, once more for
// the prefix; two vectors may wait queued.
// Reset is synchronous, active low; coarse_length resets to 64.
// in_stall rises only when the two-entry sums queue is full.
// Top level; depends on pfcs_pkg, pfcs_front, pfcs_queue, pfcs_score.
module prefix_fused_cosine_scorer_top import pfcs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [IDX_W-1:0] cfg_coarse_length,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [ELEM_W-1:0] in_query_element,
  input  logic signed [ELEM_W-1:0] in_candidate_element,
  input  logic in_last_element,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [COS_W-1:0] out_full_cosine,
  output logic signed [COS_W-1:0] out_coarse_cosine,
  output logic signed [COS_W-1:0] out_fused_score
);
  logic [IDX_W-1:0] coarse_r;
  logic qw, qfull, qv, qpop;
  sums_t qin, qout;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) coarse_r <= COARSE_RESET;
    else if (cfg_valid && cfg_ready) coarse_r <= cfg_coarse_length;
  end

  pfcs_front u_front (.clk, .rst_n, .coarse_len(coarse_r), .in_valid, .in_stall,
    .in_query_element, .in_candidate_element, .in_last_element,
    .q_valid(qw), .q_full(qfull), .q_data(qin));
  pfcs_queue u_queue (.clk, .rst_n, .wr_en(qw), .wr_data(qin), .full(qfull),
    .rd_valid(qv), .rd_en(qpop), .rd_data(qout));
  pfcs_score u_score (.clk, .rst_n, .q_valid(qv), .q_data(qout), .q_pop(qpop),
    .out_valid, .out_stall, .out_full_cosine, .out_coarse_cosine, .out_fused_score);
endmodule

// ===== bench/prefix_fused_cosine_scorer_top_tb.sv =====
// Self-checking bench for prefix_fused_cosine_scorer_top: directed table, then random vectors.
// Each accepted element word feeds an in-bench cosine scorer; output words are checked in order.
// Depends on pfcs_pkg and the scorer RTL.
module prefix_fused_cosine_scorer_top_tb;
  import pfcs_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [COS_W-1:0] full_cos;
    logic signed [COS_W-1:0] coarse_cos;
    logic signed [COS_W-1:0] fused;
  } score_t;

  typedef struct {
    logic signed [ELEM_W-1:0] q;
    logic signed [ELEM_W-1:0] c;
    bit                       last;
    bit                       typed;
    int                       full_cos;
    int                       coarse_cos;
    int                       fused;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_coarse_length = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [ELEM_W-1:0] in_query_element = '0;
  logic signed [ELEM_W-1:0] in_candidate_element = '0;
  logic in_last_element = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [COS_W-1:0] out_full_cosine;
  logic signed [COS_W-1:0] out_coarse_cosine;
  logic signed [COS_W-1:0] out_fused_score;

  prefix_fused_cosine_scorer_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_coarse_length(cfg_coarse_length),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_query_element(in_query_element), .in_candidate_element(in_candidate_element),
    .in_last_element(in_last_element),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_full_cosine(out_full_cosine), .out_coarse_cosine(out_coarse_cosine),
    .out_fused_score(out_fused_score)
  );

  always #2 clk = ~clk;

  // Scorer state mirrored in the bench
  logic [IDX_W-1:0] prefix_len = COARSE_RESET;
  longint dot_all, nq_all, nc_all, dot_pre, nq_pre, nc_pre;
  int unsigned elem_count;
  score_t pending_scores[$];
  int errors = 0;
  int cycles = 0;
  bit quiet_in = 0;
  bit quiet_out = 0;
  bit typed_next = 0;
  score_t typed_score;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic longint sat48(input longint acc, input longint p);
    longint s;
    s = acc + p;
    if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
    if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
    return s;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Normalize by an even shift, then take the root; k returns half the shift
  function automatic longint unsigned scaled_root(input longint n, output int k);
    longint unsigned v;
    v = n;
    k = 0;
    while (k < 31 && (v << 2) < (64'd1 << 62)) begin
      v <<= 2;
      k++;
    end
    return floor_sqrt(v);
  endfunction

  function automatic int cosine(input longint dot, input longint nq, input longint nc);
    int hq, hc;
    longint unsigned sq, sc, den, mag;
    logic [127:0] num, quo, rem;
    if (nq <= 0 || nc <= 0) return 0;
    sq = scaled_root(nq, hq);
    sc = scaled_root(nc, hc);
    den = sq * sc;
    if (den == 0) return 0;
    mag = dot < 0 ? -dot : dot;
    num = {64'd0, mag} << (14 + hq + hc);
    quo = num / den;
    rem = num % den;
    if (rem >= den - rem) quo++;
    if (quo > 16384) quo = 16384;
    return dot < 0 ? -int'(quo) : int'(quo);
  endfunction

  // Accumulate one accepted word; on the last word queue its score
  task automatic score_word(input logic signed [ELEM_W-1:0] q,
                            input logic signed [ELEM_W-1:0] c, input bit last);
    longint ab, aa, bb;
    int f, cr, sum;
    score_t s;
    ab = longint'(q) * longint'(c);
    aa = longint'(q) * longint'(q);
    bb = longint'(c) * longint'(c);
    dot_all = sat48(dot_all, ab);
    nq_all = sat48(nq_all, aa);
    nc_all = sat48(nc_all, bb);
    if (elem_count < prefix_len) begin
      dot_pre = sat48(dot_pre, ab);
      nq_pre = sat48(nq_pre, aa);
      nc_pre = sat48(nc_pre, bb);
    end
    if (elem_count < IDX_MAX) elem_count++;
    if (!last) return;
    f = cosine(dot_all, nq_all, nc_all);
    if (prefix_len != 0 && elem_count >= prefix_len) cr = cosine(dot_pre, nq_pre, nc_pre);
    else cr = f;
    sum = 3 * f + 2 * cr;
    s.full_cos = COS_W'(f);
    s.coarse_cos = COS_W'(cr);
    s.fused = COS_W'(sum >= 0 ? (sum + 2) / 5 : -((-sum + 2) / 5));
    // typed rows override with the value read off by hand
    if (typed_next) s = typed_score;
    pending_scores = {pending_scores, s};
    dot_all = 0; nq_all = 0; nc_all = 0;
    dot_pre = 0; nq_pre = 0; nc_pre = 0;
    elem_count = 0;
  endtask

  function automatic int gap_len(input bit quiet);
    if (quiet || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one element word and hold it until taken
  task automatic send_word(input logic signed [ELEM_W-1:0] q,
                           input logic signed [ELEM_W-1:0] c, input bit last);
    int g;
    g = gap_len(quiet_in);
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_query_element <= q;
    in_candidate_element <= c;
    in_last_element <= last;
    do @(posedge clk); while (in_stall);
    score_word(q, c, last);
  endtask

  // Wait for the pipeline to drain, then write coarse_length
  task automatic set_prefix(input logic [IDX_W-1:0] len);
    in_valid <= 0;
    wait (pending_scores.size() == 0);
    repeat (20) @(posedge clk);
    cfg_valid <= 1;
    cfg_coarse_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    prefix_len = len;
  endtask

  function automatic logic signed [ELEM_W-1:0] rand_elem(input int style);
    case (style)
      0: return ELEM_W'($urandom);
      1: return ELEM_W'(int'($urandom_range(0, 64)) - 32);
      2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return ELEM_W'(int'($urandom_range(0, 32767)) - 16384);
    endcase
  endfunction

  // One random vector; mostly well-formed content, some zero or mirrored
  task automatic send_vector(output int n);
    int style, kind;
    logic signed [ELEM_W-1:0] q, c;
    n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 24) : $urandom_range(25, 90);
    style = $urandom_range(0, 3);
    kind = $urandom_range(0, 9);
    for (int i = 0; i < n; i++) begin
      q = rand_elem(style);
      c = rand_elem(style);
      if (kind == 0) q = 0;
      else if (kind == 1) c = q;
      else if (kind == 2) c = -q;
      send_word(q, c, i == n - 1);
    end
  endtask

  row_t table_rows[$];

  function automatic row_t mk(input int q, input int c, input bit last, input bit typed,
                              input int f = 0, input int cr = 0, input int fu = 0);
    row_t r;
    r.q = ELEM_W'(q); r.c = ELEM_W'(c); r.last = last; r.typed = typed;
    r.full_cos = f; r.coarse_cos = cr; r.fused = fu;
    return r;
  endfunction

  // Append one row to the directed table
  task automatic add_row(input row_t r);
    table_rows = {table_rows, r};
  endtask

  // Output side: random stall and in-order checking
  int stall_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        report("unexpected word", out_full_cosine, 0);
      end else begin
        score_t w;
        w = pending_scores.pop_front();
        if (out_full_cosine !== w.full_cos) report("full_cosine", out_full_cosine, w.full_cos);
        if (out_coarse_cosine !== w.coarse_cos)
          report("coarse_cosine", out_coarse_cosine, w.coarse_cos);
        if (out_fused_score !== w.fused) report("fused_score", out_fused_score, w.fused);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else begin
      int g;
      g = gap_len(quiet_out);
      stall_left <= g > 0 ? g - 1 : 0;
      out_stall <= g > 0;
    end
  end

  initial begin
    int sent, n, waited;
    logic [IDX_W-1:0] phase_len[6];
    dot_all = 0; nq_all = 0; nc_all = 0;
    dot_pre = 0; nq_pre = 0; nc_pre = 0;
    elem_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, zero norms, not-last words, short vector at reset length
    add_row(mk(16384, 16384, 1, 1, 16384, 16384, 16384));
    add_row(mk(16384, -16384, 1, 1, -16384, -16384, -16384));
    add_row(mk(0, 5, 1, 1, 0, 0, 0));
    add_row(mk(7, 0, 1, 1, 0, 0, 0));
    add_row(mk(-32768, -32768, 1, 1, 16384, 16384, 16384));
    add_row(mk(32767, 32767, 1, 1, 16384, 16384, 16384));
    add_row(mk(-32768, 32767, 1, 0));
    add_row(mk(32767, -32768, 0, 0));
    add_row(mk(-32768, -32768, 0, 0));
    add_row(mk(1, -1, 1, 0));
    add_row(mk(16384, 0, 0, 0));
    add_row(mk(0, 16384, 1, 1, 0, 0, 0));
    add_row(mk(12000, -3, 0, 0));
    add_row(mk(-5, 9000, 0, 0));
    add_row(mk(21845, 21845, 0, 0));
    add_row(mk(-1, 1, 1, 0));
    add_row(mk(0, 0, 0, 0));
    add_row(mk(0, 0, 1, 1, 0, 0, 0));
    foreach (table_rows[i]) begin
      typed_next = table_rows[i].typed && table_rows[i].last;
      typed_score.full_cos = COS_W'(table_rows[i].full_cos);
      typed_score.coarse_cos = COS_W'(table_rows[i].coarse_cos);
      typed_score.fused = COS_W'(table_rows[i].fused);
      send_word(table_rows[i].q, table_rows[i].c, table_rows[i].last);
    end
    typed_next = 0;

    // Random phases over several prefix lengths, extremes included
    phase_len[0] = 16; phase_len[1] = 0; phase_len[2] = 8191;
    phase_len[3] = 4096; phase_len[4] = 37; phase_len[5] = 64;
    sent = 0;
    for (int p = 0; p < 6; p++) begin
      set_prefix(phase_len[p]);
      quiet_in = (p == 3);
      quiet_out = (p == 4);
      while (sent < (p + 1) * 140) begin
        send_vector(n);
        sent += n;
      end
    end
    in_valid <= 0;

    waited = 0;
    while (pending_scores.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_scores.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/pfcs_pkg.sv
design/pfcs_front.sv
design/pfcs_queue.sv
design/pfcs_score.sv
design/prefix_fused_cosine_scorer_top.sv
bench/prefix_fused_cosine_scorer_top_tb.sv
